FILE: src/mph_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mph_pkg
// Shared types and constants for the multi-stream prefix heatmap block.
// ---------------------------------------------------------------------------
package mph_pkg;

    // default sizing
    localparam int MAX_REQUESTS_DEF = 10;
    localparam int BODY_BYTES_DEF   = 65536;
    localparam int MAX_BUCKETS_DEF  = 64;

    // fixed field widths
    localparam int SLOT_PORT_W = 4;
    localparam int BYTE_W      = 8;
    localparam int RC_W        = 4;
    localparam int BL_W        = 7;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int TENTHS_W    = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LIMIT  = 1'b1;

    // reset values of the configuration registers
    localparam logic [RC_W-1:0] RC_RESET = 4'd4;
    localparam logic [BL_W-1:0] BL_RESET = 7'd64;

    // command queue between front and back
    localparam int Q_DEPTH = 2;

    // twice the scale for tenths of a percent, so the percentage divide rounds
    localparam int TENTHS_SCALE = 2000;

    // one queued command
    typedef struct packed {
        logic                   is_run;
        logic [SLOT_PORT_W-1:0] slot;
        logic [BYTE_W-1:0]      data;
    } mph_cmd_t;

endpackage

FILE: src/mph_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mph_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mph_divider #(
    parameter int DIVW = 32,
    parameter int DSW  = 21
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic [DIVW-1:0] dividend,
    input  logic [DSW-1:0]  divisor,
    output logic [DIVW-1:0] quotient,
    output logic [DSW-1:0]  remainder,
    output logic            done
);
    localparam int CW = $clog2(DIVW + 1);

    logic            run_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DIVW-1:0] dq_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DSW-1:0]  dsr_reg;
    logic [DSW:0]    trial;
    logic            ge;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, dq_reg[DIVW-1]};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DIVW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            dq_reg <= {dq_reg[DIVW-2:0], ge};
            if (ge)
                rem_reg <= DSW'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[DSW-1:0];
        end
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: src/mph_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mph_front
// Configuration registers, command intake and filtering, command queue.
// ---------------------------------------------------------------------------
module mph_front #(
    parameter int MAX_REQUESTS = mph_pkg::MAX_REQUESTS_DEF,
    parameter int MAX_BUCKETS  = mph_pkg::MAX_BUCKETS_DEF,
    parameter int CNT_W        = $clog2(MAX_REQUESTS + 1),
    parameter int NB_W         = $clog2(MAX_BUCKETS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [mph_pkg::SLOT_PORT_W-1:0] request_slot,
    input  logic [mph_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            cfg_we,
    input  logic [mph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mph_pkg::CFG_W-1:0]       cfg_data,
    output logic [CNT_W-1:0]                eff_count,
    output logic [NB_W-1:0]                 eff_buckets,
    output logic                            cmd_valid,
    output mph_pkg::mph_cmd_t               cmd,
    input  logic                            cmd_pop
);
    import mph_pkg::*;

    localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    logic [RC_W-1:0]   rc_reg;
    logic [BL_W-1:0]   bl_reg;
    mph_cmd_t          q_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              accept;
    logic              push;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= RC_RESET;
            bl_reg <= BL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REQUEST_COUNT: rc_reg <= cfg_data[RC_W-1:0];
                REG_BUCKET_LIMIT:  bl_reg <= cfg_data[BL_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate register values into their useful ranges
    always_comb
    begin
        if (rc_reg < RC_W'(2))
            eff_count = CNT_W'(2);
        else if ({1'b0, rc_reg} > (RC_W+1)'(MAX_REQUESTS))
            eff_count = CNT_W'(MAX_REQUESTS);
        else
            eff_count = CNT_W'(rc_reg);

        if (bl_reg < BL_W'(1))
            eff_buckets = NB_W'(1);
        else if ({1'b0, bl_reg} > (BL_W+1)'(MAX_BUCKETS))
            eff_buckets = NB_W'(MAX_BUCKETS);
        else
            eff_buckets = NB_W'(bl_reg);
    end

    // intake: bytes for slots not compared are dropped here
    assign busy   = (fill_reg == QCNT_W'(Q_DEPTH));
    assign accept = start && !busy;
    assign push   = accept &&
                    (action || ({1'b0, request_slot} < (SLOT_PORT_W+1)'(eff_count)));

    // command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
            if (cmd_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
            if (push && !cmd_pop)
                fill_reg <= fill_reg + QCNT_W'(1);
            else if (!push && cmd_pop)
                fill_reg <= fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].is_run <= action;
            q_reg[wr_ptr_reg].slot   <= request_slot;
            q_reg[wr_ptr_reg].data   <= data_byte;
        end
    end

    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

endmodule

FILE: src/mph_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mph_back
// Body store, length table and the run sequencer that walks stored bytes.
// ---------------------------------------------------------------------------
module mph_back #(
    parameter int MAX_REQUESTS = mph_pkg::MAX_REQUESTS_DEF,
    parameter int BODY_BYTES   = mph_pkg::BODY_BYTES_DEF,
    parameter int MAX_BUCKETS  = mph_pkg::MAX_BUCKETS_DEF,
    parameter int CNT_W        = $clog2(MAX_REQUESTS + 1),
    parameter int NB_W         = $clog2(MAX_BUCKETS + 1),
    parameter int LEN_W        = $clog2(BODY_BYTES + 1),
    parameter int BKT_W        = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int MATCH_W      = $clog2(MAX_REQUESTS * BODY_BYTES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CNT_W-1:0]             eff_count,
    input  logic [NB_W-1:0]              eff_buckets,
    input  logic                         cmd_valid,
    input  mph_pkg::mph_cmd_t            cmd,
    output logic                         cmd_pop,
    output logic                         done,
    output logic [LEN_W-1:0]             prefix_length,
    output logic [LEN_W-1:0]             baseline_length,
    output logic [BKT_W-1:0]             bucket_number,
    output logic [LEN_W-1:0]             bucket_start,
    output logic [LEN_W-1:0]             bucket_end,
    output logic [MATCH_W-1:0]           match_count,
    output logic [MATCH_W-1:0]           possible_count,
    output logic [mph_pkg::TENTHS_W-1:0] match_tenths,
    output logic                         bucket_valid,
    output logic                         last_result
);
    import mph_pkg::*;

    localparam int SLOT_W    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int MEM_DEPTH = MAX_REQUESTS * BODY_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DIVW      = MATCH_W + 12;
    localparam int DSW       = MATCH_W + 1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MINLEN = 14'b00000000000010,
        S_PREFIX = 14'b00000000000100,
        S_PDRAIN = 14'b00000000001000,
        S_LGO    = 14'b00000000010000,
        S_LDIV   = 14'b00000000100000,
        S_BSET   = 14'b00000001000000,
        S_BWALK  = 14'b00000010000000,
        S_BDRAIN = 14'b00000100000000,
        S_BMUL   = 14'b00001000000000,
        S_BGO    = 14'b00010000000000,
        S_BDIV   = 14'b00100000000000,
        S_EMIT   = 14'b01000000000000,
        S_EMPTY  = 14'b10000000000000
    } state_t;

    state_t             state_reg;
    logic [BYTE_W-1:0]  mem [MEM_DEPTH];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [LEN_W-1:0]   len_reg [MAX_REQUESTS];

    logic [LEN_W-1:0]   base_reg;
    logic [LEN_W-1:0]   minlen_reg;
    logic [LEN_W-1:0]   prefix_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               d_v_reg;
    logic [LEN_W-1:0]   d_pos_reg;
    logic [SLOT_W-1:0]  d_slot_reg;
    logic [BYTE_W-1:0]  base_byte_reg;
    logic [NB_W-1:0]    nb_reg;
    logic [LEN_W-1:0]   step_q_reg;
    logic [NB_W-1:0]    step_r_reg;
    logic [LEN_W-1:0]   cur_start_reg;
    logic [NB_W-1:0]    cur_r_reg;
    logic [LEN_W-1:0]   end_reg;
    logic [NB_W-1:0]    end_r_reg;
    logic [BKT_W-1:0]   b_reg;
    logic [MATCH_W-1:0] matches_reg;
    logic [MATCH_W-1:0] poss_reg;
    logic [DIVW-1:0]    m2k_reg;
    logic [TENTHS_W-1:0] tenths_reg;

    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  len_idx;
    logic [LEN_W-1:0]   len_sel;
    logic               last_slot;
    logic               issue;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;
    logic               prefix_mode;
    logic [NB_W-1:0]    nb_next;
    logic [NB_W:0]      sum_r;
    logic               is_last_bkt;

    logic               div_go;
    logic [DIVW-1:0]    div_dividend;
    logic [DSW-1:0]     div_divisor;
    logic [DIVW-1:0]    div_q;
    logic [DSW-1:0]     div_r;
    logic               div_done;

    // shared divider: bucket step first, then each bucket's percentage
    mph_divider #(
        .DIVW (DIVW),
        .DSW  (DSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // length table read port
    assign head_slot = cmd.slot[SLOT_W-1:0];
    always_comb
    begin
        if (state_reg == S_IDLE)
            len_idx = head_slot;
        else if (state_reg == S_MINLEN)
            len_idx = i_reg[SLOT_W-1:0];
        else
            len_idx = d_slot_reg;
    end
    assign len_sel = len_reg[len_idx];

    // walk address and control
    assign last_slot   = ((CNT_W'(slot_reg) + CNT_W'(1)) == eff_count);
    assign issue       = (state_reg == S_PREFIX) || (state_reg == S_BWALK);
    assign rd_addr     = ADDR_W'(slot_reg) * ADDR_W'(BODY_BYTES) + ADDR_W'(pos_reg);
    assign wr_addr     = ADDR_W'(head_slot) * ADDR_W'(BODY_BYTES) + ADDR_W'(len_sel);
    assign wr_en       = (state_reg == S_IDLE) && cmd_valid && !cmd.is_run &&
                         (len_sel < LEN_W'(BODY_BYTES));
    assign cmd_pop     = (state_reg == S_IDLE) && cmd_valid;
    assign prefix_mode = (state_reg == S_PREFIX) || (state_reg == S_PDRAIN);

    // bucket count and next bucket end
    assign nb_next     = (LEN_W'(eff_buckets) < base_reg) ? eff_buckets : NB_W'(base_reg);
    assign sum_r       = (NB_W+1)'(cur_r_reg) + (NB_W+1)'(step_r_reg);
    assign is_last_bkt = ((NB_W'(b_reg) + NB_W'(1)) == nb_reg);

    // divider operands
    always_comb
    begin
        div_go       = (state_reg == S_LGO) || (state_reg == S_BGO);
        div_dividend = DIVW'(base_reg);
        div_divisor  = DSW'(nb_next);
        if (state_reg == S_BGO)
        begin
            div_dividend = m2k_reg + DIVW'(poss_reg);
            div_divisor  = {poss_reg, 1'b0};
        end
    end

    // body store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= cmd.data;
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            d_v_reg   <= 1'b0;
            for (int k = 0; k < MAX_REQUESTS; k++)
                len_reg[k] <= '0;
        end
        else
        begin
            d_v_reg <= issue;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (!cmd.is_run)
                        begin
                            if (wr_en)
                                len_reg[head_slot] <= len_sel + LEN_W'(1);
                        end
                        else if (len_reg[0] == '0)
                            state_reg <= S_EMPTY;
                        else
                            state_reg <= S_MINLEN;
                    end
                end
                S_MINLEN:
                begin
                    if (i_reg == eff_count)
                    begin
                        if (minlen_reg == '0)
                            state_reg <= S_LGO;
                        else
                            state_reg <= S_PREFIX;
                    end
                end
                S_PREFIX:
                begin
                    if (last_slot && (pos_reg == minlen_reg - LEN_W'(1)))
                        state_reg <= S_PDRAIN;
                end
                S_PDRAIN: state_reg <= S_LGO;
                S_LGO:    state_reg <= S_LDIV;
                S_LDIV:
                begin
                    if (div_done)
                        state_reg <= S_BSET;
                end
                S_BSET:   state_reg <= S_BWALK;
                S_BWALK:
                begin
                    if (last_slot && (pos_reg == end_reg - LEN_W'(1)))
                        state_reg <= S_BDRAIN;
                end
                S_BDRAIN: state_reg <= S_BMUL;
                S_BMUL:   state_reg <= S_BGO;
                S_BGO:    state_reg <= S_BDIV;
                S_BDIV:
                begin
                    if (div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (is_last_bkt)
                    begin
                        state_reg <= S_IDLE;
                        for (int k = 0; k < MAX_REQUESTS; k++)
                            len_reg[k] <= '0;
                    end
                    else
                        state_reg <= S_BSET;
                end
                S_EMPTY:
                begin
                    state_reg <= S_IDLE;
                    for (int k = 0; k < MAX_REQUESTS; k++)
                        len_reg[k] <= '0;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // run datapath
    always_ff @(posedge clk)
    begin
        d_pos_reg  <= pos_reg;
        d_slot_reg <= slot_reg;

        // start of a run
        if ((state_reg == S_IDLE) && cmd_valid && cmd.is_run)
        begin
            base_reg   <= len_reg[0];
            minlen_reg <= len_reg[0];
            prefix_reg <= '0;
            found_reg  <= 1'b0;
            i_reg      <= CNT_W'(1);
            b_reg      <= '0;
        end

        // shortest length over the compared bodies
        if (state_reg == S_MINLEN)
        begin
            if (i_reg != eff_count)
            begin
                if (len_sel < minlen_reg)
                    minlen_reg <= len_sel;
                i_reg <= i_reg + CNT_W'(1);
            end
            else
            begin
                prefix_reg <= minlen_reg;
                pos_reg    <= '0;
                slot_reg   <= '0;
            end
        end

        // walk position counter, slot inner and position outer
        if (issue)
        begin
            if (last_slot)
            begin
                slot_reg <= '0;
                pos_reg  <= pos_reg + LEN_W'(1);
            end
            else
                slot_reg <= slot_reg + SLOT_W'(1);
        end

        // compare stage behind the store read
        if (d_v_reg)
        begin
            if (d_slot_reg == '0)
            begin
                base_byte_reg <= rd_data_reg;
                if (!prefix_mode)
                    matches_reg <= matches_reg + MATCH_W'(1);
            end
            else if (prefix_mode)
            begin
                if ((rd_data_reg != base_byte_reg) && !found_reg)
                begin
                    found_reg  <= 1'b1;
                    prefix_reg <= d_pos_reg;
                end
            end
            else if ((d_pos_reg < len_sel) && (rd_data_reg == base_byte_reg))
                matches_reg <= matches_reg + MATCH_W'(1);
        end

        // bucket geometry
        if (state_reg == S_LGO)
            nb_reg <= nb_next;
        if ((state_reg == S_LDIV) && div_done)
        begin
            step_q_reg    <= div_q[LEN_W-1:0];
            step_r_reg    <= div_r[NB_W-1:0];
            cur_start_reg <= '0;
            cur_r_reg     <= '0;
        end
        if (state_reg == S_BSET)
        begin
            if (sum_r >= (NB_W+1)'(nb_reg))
            begin
                end_reg   <= cur_start_reg + step_q_reg + LEN_W'(1);
                end_r_reg <= NB_W'(sum_r - (NB_W+1)'(nb_reg));
            end
            else
            begin
                end_reg   <= cur_start_reg + step_q_reg;
                end_r_reg <= sum_r[NB_W-1:0];
            end
            pos_reg     <= cur_start_reg;
            slot_reg    <= '0;
            matches_reg <= '0;
        end

        // percentage operands
        if (state_reg == S_BMUL)
        begin
            poss_reg <= MATCH_W'(end_reg - cur_start_reg) * MATCH_W'(eff_count);
            m2k_reg  <= DIVW'(matches_reg) * DIVW'(TENTHS_SCALE);
        end
        if ((state_reg == S_BDIV) && div_done)
            tenths_reg <= (poss_reg == '0) ? '0 : div_q[TENTHS_W-1:0];

        // move to the next bucket
        if ((state_reg == S_EMIT) && !is_last_bkt)
        begin
            b_reg         <= b_reg + BKT_W'(1);
            cur_start_reg <= end_reg;
            cur_r_reg     <= end_r_reg;
        end
    end

    // result ports
    always_comb
    begin
        done            = (state_reg == S_EMIT) || (state_reg == S_EMPTY);
        bucket_valid    = (state_reg == S_EMIT);
        last_result     = (state_reg == S_EMPTY) || is_last_bkt;
        prefix_length   = '0;
        baseline_length = '0;
        bucket_number   = '0;
        bucket_start    = '0;
        bucket_end      = '0;
        match_count     = '0;
        possible_count  = '0;
        match_tenths    = '0;
        if (state_reg == S_EMIT)
        begin
            prefix_length   = prefix_reg;
            baseline_length = base_reg;
            bucket_number   = b_reg;
            bucket_start    = cur_start_reg;
            bucket_end      = end_reg;
            match_count     = matches_reg;
            possible_count  = poss_reg;
            match_tenths    = tenths_reg;
        end
    end

endmodule

FILE: src/multi_stream_prefix_heatmap_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_stream_prefix_heatmap_top
// Stores request bodies byte by byte and on a run reports the shared prefix
// and a per-bucket match heatmap against the baseline body.
// ---------------------------------------------------------------------------
// usage
//   command channel: start/busy; a transfer happens when start is high and
//   busy is low. action 0 appends data_byte to body request_slot, action 1
//   runs the analysis. busy only rises when the two-entry command queue is full.
//   config: cfg_we/cfg_index/cfg_data, written while the block is idle.
//   results: one per bucket, each on the ports for a single cycle with done
//   high; the receiver cannot stall, so there is no back-pressure on results.
// timing
//   an append passes through the command queue and is written to the body
//   store, one per cycle while no run is in progress. a run over N bodies
//   finds the shortest length M, walks the first M bytes of every body and
//   divides for the bucket step; then for each of B buckets it walks the
//   bucket's bytes of all N bodies and divides for the percentage, paced by
//   the single read port of the body store and the shared bit-serial divider
//   (DIVW = 32 at default sizes). an empty baseline gives one result with bucket_valid low.
// reset
//   all body lengths clear, request_count returns to 4 and bucket_limit to 64;
//   body store contents are left as they are and need no clearing pass.
// ---------------------------------------------------------------------------
module multi_stream_prefix_heatmap_top #(
    parameter int MAX_REQUESTS = mph_pkg::MAX_REQUESTS_DEF,
    parameter int BODY_BYTES   = mph_pkg::BODY_BYTES_DEF,
    parameter int MAX_BUCKETS  = mph_pkg::MAX_BUCKETS_DEF,
    parameter int LEN_W        = $clog2(BODY_BYTES + 1),
    parameter int BKT_W        = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int MATCH_W      = $clog2(MAX_REQUESTS * BODY_BYTES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [mph_pkg::SLOT_PORT_W-1:0] request_slot,
    input  logic [mph_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            cfg_we,
    input  logic [mph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mph_pkg::CFG_W-1:0]       cfg_data,
    output logic                            done,
    output logic [LEN_W-1:0]                prefix_length,
    output logic [LEN_W-1:0]                baseline_length,
    output logic [BKT_W-1:0]                bucket_number,
    output logic [LEN_W-1:0]                bucket_start,
    output logic [LEN_W-1:0]                bucket_end,
    output logic [MATCH_W-1:0]              match_count,
    output logic [MATCH_W-1:0]              possible_count,
    output logic [mph_pkg::TENTHS_W-1:0]    match_tenths,
    output logic                            bucket_valid,
    output logic                            last_result
);
    import mph_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int NB_W  = $clog2(MAX_BUCKETS + 1);

    logic [CNT_W-1:0] eff_count;
    logic [NB_W-1:0]  eff_buckets;
    logic             cmd_valid;
    mph_cmd_t         cmd;
    logic             cmd_pop;

    // intake and configuration
    mph_front #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .MAX_BUCKETS  (MAX_BUCKETS),
        .CNT_W        (CNT_W),
        .NB_W         (NB_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .request_slot (request_slot),
        .data_byte    (data_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .eff_count    (eff_count),
        .eff_buckets  (eff_buckets),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // storage and run sequencer
    mph_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .BODY_BYTES   (BODY_BYTES),
        .MAX_BUCKETS  (MAX_BUCKETS),
        .CNT_W        (CNT_W),
        .NB_W         (NB_W),
        .LEN_W        (LEN_W),
        .BKT_W        (BKT_W),
        .MATCH_W      (MATCH_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .eff_count       (eff_count),
        .eff_buckets     (eff_buckets),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .done            (done),
        .prefix_length   (prefix_length),
        .baseline_length (baseline_length),
        .bucket_number   (bucket_number),
        .bucket_start    (bucket_start),
        .bucket_end      (bucket_end),
        .match_count     (match_count),
        .possible_count  (possible_count),
        .match_tenths    (match_tenths),
        .bucket_valid    (bucket_valid),
        .last_result     (last_result)
    );

endmodule

FILE: src/mph_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mph_checker
// Port-level checks on the heatmap results, bound to the top level.
// ---------------------------------------------------------------------------
module mph_checker #(
    parameter int LEN_W   = 17,
    parameter int MATCH_W = 20
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            done,
    input logic                            bucket_valid,
    input logic                            last_result,
    input logic [LEN_W-1:0]                bucket_start,
    input logic [LEN_W-1:0]                bucket_end,
    input logic [MATCH_W-1:0]              match_count,
    input logic [MATCH_W-1:0]              possible_count,
    input logic [mph_pkg::TENTHS_W-1:0]    match_tenths
);
    // empty baseline result closes the run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && !bucket_valid |-> last_result)
        else $error("empty result without last flag");

    // counts stay within what is possible
    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done && bucket_valid |-> (match_count <= possible_count) &&
                                 (match_tenths <= 10'd1000))
        else $error("match count or percentage out of range");

    // every bucket covers at least one position
    a_bucket_span: assert property (@(posedge clk) disable iff (!rst_n)
        done && bucket_valid |-> bucket_end > bucket_start)
        else $error("empty bucket");

    // the next bucket of a run needs a walk, so results never come back to back
    a_bucket_chain: assert property (@(posedge clk) disable iff (!rst_n)
        done && bucket_valid && !last_result |=> !done)
        else $error("results back to back within a run");

endmodule

bind multi_stream_prefix_heatmap_top mph_checker #(
    .LEN_W   (LEN_W),
    .MATCH_W (MATCH_W)
) u_mph_checker (.*);
